/* rtl/chi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_pkg
// Shared types and constants of the two-table cuckoo insertion core.
// ----------------------------------------------------------------------------
package chi_pkg;

  // Default sizes of the design.
  localparam int unsigned TABLE_SLOTS_DEF = 10;
  localparam int unsigned KEY_CHARS_DEF   = 8;

  // Fixed field widths of the channels.
  localparam int unsigned CHARS_W = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned KICK_W  = 9;
  localparam int unsigned MAXK_W  = 8;

  // Hash multipliers of the two tables and the reset depth limit.
  localparam int unsigned MUL_FIRST  = 37;
  localparam int unsigned MUL_SECOND = 13;
  localparam logic [MAXK_W-1:0] MAX_KICKS_RESET = 8'd20;

  // One key item.
  typedef struct packed {
    logic [CHARS_W-1:0] key_chars;
    logic [LEN_W-1:0]   key_len;
  } key_t;

  // One result item.
  typedef struct packed {
    logic               status;
    logic               final_table;
    logic [SLOT_W-1:0]  final_slot;
    logic [KICK_W-1:0]  kick_count;
    logic [CHARS_W-1:0] dropped_chars;
    logic [LEN_W-1:0]   dropped_len;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;      // write an empty entry at the clearing address
    logic load_key;    // take a new key and start hashing it
    logic hash_start;  // restart hashing with the carried key
    logic hash_a;      // first half of one character step
    logic hash_b;      // second half of one character step
    logic rd_en;       // read the target slot
    logic wr_en;       // write the carried key into the target slot
    logic evict;       // carry the evicted key on to the other table
    logic drop;        // mark the carried key as dropped
    logic load_res;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clearing address is the last slot
    logic hash_done;   // all characters of the carried key hashed
    logic slot_empty;  // slot just read held no key
    logic over_limit;  // eviction depth beyond the limit
  } stat_t;

endpackage : chi_pkg
`default_nettype wire

/* rtl/chi_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface chi_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : chi_chan_if
`default_nettype wire

/* rtl/chi_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_hash
// Character-serial slot hash, each character taken in an A and a B step.
// ----------------------------------------------------------------------------
module chi_hash #(
  parameter int unsigned TABLE_SLOTS = chi_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_CHARS   = chi_pkg::KEY_CHARS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   start_i,
  input  wire logic                                   step_a_i,
  input  wire logic                                   step_b_i,
  input  wire logic                                   tbl_i,
  input  wire logic [8*KEY_CHARS-1:0]                 chars_i,
  input  wire logic [chi_pkg::LEN_W-1:0]              len_i,
  output logic      [$clog2(TABLE_SLOTS)-1:0]         slot_o,
  output logic                                        done_o
);
  import chi_pkg::*;

  localparam int unsigned HW = $clog2(TABLE_SLOTS);
  localparam int unsigned KW = 8 * KEY_CHARS;
  // h*mul + c stays below TABLE_SLOTS << 8, which fits in HW + 9 bits.
  localparam int unsigned XW = HW + 9;

  logic [HW-1:0]    h_q;
  logic [XW-1:0]    x_q;
  logic [KW-1:0]    sr_q;
  logic [LEN_W-1:0] rem_q;
  logic [XW-1:0]    prod, xa, xb;

  // The remainder is taken by restoring subtraction of TABLE_SLOTS << k,
  // the upper four steps on step A, registered, and the lower four on step B.
  always_comb begin
    prod = XW'(h_q) * (tbl_i ? XW'(MUL_SECOND) : XW'(MUL_FIRST)) + XW'(sr_q[7:0]);
    xa   = prod;
    for (int k = 7; k >= 4; k--) begin
      if (xa >= (XW'(TABLE_SLOTS) << k)) begin
        xa = xa - (XW'(TABLE_SLOTS) << k);
      end
    end
    xb = x_q;
    for (int k = 3; k >= 0; k--) begin
      if (xb >= (XW'(TABLE_SLOTS) << k)) begin
        xb = xb - (XW'(TABLE_SLOTS) << k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= '0;
      sr_q  <= chars_i;
      rem_q <= len_i;
    end else if (step_a_i) begin
      x_q <= xa;
    end else if (step_b_i) begin
      h_q   <= HW'(xb);
      sr_q  <= sr_q >> 8;
      rem_q <= rem_q - LEN_W'(1);
    end
  end

  assign slot_o = h_q;
  assign done_o = (rem_q == '0);

endmodule : chi_hash
`default_nettype wire

/* rtl/chi_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_dp
// Datapath: the two slot tables, the carried key, the depth counter, the
// limit register and the result register.
// ----------------------------------------------------------------------------
module chi_dp #(
  parameter int unsigned TABLE_SLOTS = chi_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_CHARS   = chi_pkg::KEY_CHARS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire chi_pkg::cmd_t                  cmd_i,
  output chi_pkg::stat_t                      stat_o,
  input  wire chi_pkg::key_t                  key_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [chi_pkg::MAXK_W-1:0]     cfg_data_i,
  output chi_pkg::res_t                       res_o
);
  import chi_pkg::*;

  localparam int unsigned HW    = $clog2(TABLE_SLOTS);
  localparam int unsigned KW    = 8 * KEY_CHARS;
  localparam int unsigned ENT_W = LEN_W + KW;

  // Slot tables; an entry is {length, characters}, empty when length is zero.
  logic [ENT_W-1:0] t0_mem [TABLE_SLOTS];
  logic [ENT_W-1:0] t1_mem [TABLE_SLOTS];
  logic [ENT_W-1:0] rd0_q, rd1_q, old_ent, wr_ent;

  logic [HW-1:0]     clr_cnt_q;
  logic [MAXK_W-1:0] max_kicks_q;
  logic [KW-1:0]     carry_chars_q, in_chars;
  logic [LEN_W-1:0]  carry_len_q, in_len;
  logic              tbl_q, drop_q, last_tbl_q;
  logic [HW-1:0]     last_slot_q, slot, wr_addr;
  logic [KICK_W-1:0] depth_q;
  logic              hash_done;
  res_t              res_q;

  // Clamp the length and zero the characters beyond it.
  always_comb begin
    in_len = (key_i.key_len > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS) : key_i.key_len;
    for (int b = 0; b < int'(KEY_CHARS); b++) begin
      in_chars[8*b +: 8] = (LEN_W'(b) < in_len) ? key_i.key_chars[8*b +: 8] : 8'h00;
    end
  end

  chi_hash #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_CHARS  (KEY_CHARS)
  ) u_hash (
    .clk_i   (clk_i),
    .start_i (cmd_i.load_key | cmd_i.hash_start),
    .step_a_i(cmd_i.hash_a),
    .step_b_i(cmd_i.hash_b),
    .tbl_i   (cmd_i.load_key ? 1'b0 : tbl_q),
    .chars_i (cmd_i.load_key ? in_chars : carry_chars_q),
    .len_i   (cmd_i.load_key ? in_len : carry_len_q),
    .slot_o  (slot),
    .done_o  (hash_done)
  );

  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : slot;
  assign wr_ent  = cmd_i.clr_wr ? '0 : {carry_len_q, carry_chars_q};
  assign old_ent = tbl_q ? rd1_q : rd0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || (cmd_i.wr_en && !tbl_q)) begin
      t0_mem[wr_addr] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= t0_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || (cmd_i.wr_en && tbl_q)) begin
      t1_mem[wr_addr] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rd1_q <= t1_mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      max_kicks_q <= MAX_KICKS_RESET;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + HW'(1);
      end
      if (cfg_we_i) begin
        max_kicks_q <= cfg_data_i;
      end
    end
  end

  // Carried key and bookkeeping of the current insertion.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      carry_chars_q <= in_chars;
      carry_len_q   <= in_len;
      tbl_q         <= 1'b0;
      depth_q       <= '0;
      drop_q        <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        last_tbl_q  <= tbl_q;
        last_slot_q <= slot;
      end
      if (cmd_i.evict) begin
        carry_chars_q <= old_ent[KW-1:0];
        carry_len_q   <= old_ent[ENT_W-1:KW];
        tbl_q         <= ~tbl_q;
        depth_q       <= depth_q + KICK_W'(1);
      end
      if (cmd_i.drop) begin
        drop_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_q.status        <= drop_q;
      res_q.final_table   <= last_tbl_q;
      res_q.final_slot    <= SLOT_W'(last_slot_q);
      res_q.kick_count    <= depth_q;
      res_q.dropped_chars <= drop_q ? CHARS_W'(carry_chars_q) : '0;
      res_q.dropped_len   <= drop_q ? carry_len_q : '0;
    end
  end

  assign res_o             = res_q;
  assign stat_o.clr_last   = (clr_cnt_q == HW'(TABLE_SLOTS - 1));
  assign stat_o.hash_done  = hash_done;
  assign stat_o.slot_empty = (old_ent[ENT_W-1:KW] == '0);
  assign stat_o.over_limit = (depth_q > KICK_W'(max_kicks_q));

endmodule : chi_dp
`default_nettype wire

/* rtl/chi_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chi_ctrl
// Controller: sequences clearing, hashing, slot read, write and eviction,
// and owns the item handshakes.
// ----------------------------------------------------------------------------
module chi_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           key_valid_i,
  output logic                key_ready_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  input  wire chi_pkg::stat_t stat_i,
  output chi_pkg::cmd_t       cmd_o
);
  import chi_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH_A = 3'd2;
  localparam logic [2:0] S_HASH_B = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_CHECK  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    key_ready_o = 1'b0;
    out_valid_d = out_valid_q && !res_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        key_ready_o = 1'b1;
        if (key_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = S_HASH_A;
        end
      end
      S_HASH_A: begin
        if (stat_i.hash_done) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_READ;
        end else begin
          cmd_o.hash_a = 1'b1;
          state_d      = S_HASH_B;
        end
      end
      S_HASH_B: begin
        cmd_o.hash_b = 1'b1;
        state_d      = S_HASH_A;
      end
      S_READ: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.slot_empty) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.evict = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.over_limit) begin
          cmd_o.drop = 1'b1;
          state_d    = S_FINISH;
        end else begin
          cmd_o.hash_start = 1'b1;
          state_d          = S_HASH_A;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.load_res = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule : chi_ctrl
`default_nettype wire

/* rtl/cuckoo_hash_insert_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cuckoo_hash_insert_core
// Two-table cuckoo insertion of short character keys, one result per key.
// ----------------------------------------------------------------------------
// Each key item is inserted into a pair of slot tables. The key is hashed
// into the first table and written there; a key it displaces is carried to
// the other table at its own hash, and so on, alternating tables, until a
// key lands in an empty slot or the eviction depth passes max_kicks, in which
// case the carried key is dropped and returned in the result. After reset
// the core first empties both tables, one slot of each per cycle; key items
// are held off meanwhile, while the limit register may be written at any
// time. An insertion is accepted in the idle state and then, for every slot
// visited, the character-serial hash takes each character of the key carried
// at that step in an A and a B step, after which the slot is read and then
// written. Each eviction adds a depth check before the next visit, and the
// result is loaded in the finish state after the last visit or the last
// check, once the result register is free or its result is being taken.
// The result sits in its own register, so a finished result waiting to be
// taken does not stop the next key from being accepted and worked on.
// ----------------------------------------------------------------------------
module cuckoo_hash_insert_core #(
  parameter int unsigned TABLE_SLOTS = chi_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_CHARS   = chi_pkg::KEY_CHARS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chi_chan_if.sink   key_i,
  chi_chan_if.source res_o,
  chi_chan_if.sink   cfg_i
);
  import chi_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  // The limit register takes a write in any cycle.
  assign cfg_i.ready = 1'b1;

  chi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_valid_i(key_i.valid),
    .key_ready_o(key_i.ready),
    .res_valid_o(res_o.valid),
    .res_ready_i(res_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chi_dp #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_CHARS  (KEY_CHARS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .key_i     (key_i.data),
    .cfg_we_i  (cfg_i.valid),
    .cfg_data_i(cfg_i.data),
    .res_o     (res)
  );

  assign res_o.data = res;

  // Once a key is taken the core does not take another in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready) |=> !key_i.ready)
    else $error("key accepted while the previous insertion is still running");

  // A placed key reports no dropped key.
  a_no_drop_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.status) |->
      (res_o.data.dropped_len == '0 && res_o.data.dropped_chars == '0))
    else $error("dropped key reported for a successful insertion");

  // A drop always follows at least one eviction.
  a_drop_needs_kick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.status) |-> (res_o.data.kick_count != '0))
    else $error("key dropped without any eviction");

  // The table port is never written by the clearing pass and an insertion
  // at the same time.
  a_clear_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> (!cmd.wr_en && !key_i.ready))
    else $error("clearing pass overlaps an insertion");

endmodule : cuckoo_hash_insert_core
`default_nettype wire

/* test/tb_cuckoo_hash_insert_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cuckoo_hash_insert_core
// Self-checking bench for the two-table cuckoo insertion core.
// ----------------------------------------------------------------------------
// Keys are pushed through the key channel and every result item is compared,
// field by field, against a behavioural model of the two slot tables that
// the bench keeps alongside the core. A short directed table comes first,
// some of its rows carrying a hand-worked result. Random phases follow, each
// run under its own eviction limit. The limit is only changed while the core
// is empty. Both channels stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_insert_core;
  import chi_pkg::*;

  // A directed row: the key, and the result when it is worked out by hand.
  typedef struct packed {
    key_t k;
    logic fixed;
    res_t r;
  } row_t;

  // What the monitor must expect for the next accepted key.
  typedef struct packed {
    logic fixed;
    res_t r;
  } preset_t;

  localparam int unsigned N_DIRECTED = 16;
  localparam int unsigned N_PHASES   = 7;

  // Hand-worked rows follow the table contents from reset onwards. 'A' is
  // 0x41, which lands in slot 5 of either table. Eight 0xFF characters hash
  // to slot 0 of either table.
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // first key into empty tables
    '{'{64'h0000_0000_0000_0041, 4'd1}, 1'b1, '{1'b0, 1'b0, 4'd5, 9'd0, 64'd0, 4'd0}},
    // zero length key: slot 0 of the first table is written but stays empty
    '{'{64'h0000_0000_0000_1234, 4'd0}, 1'b1, '{1'b0, 1'b0, 4'd0, 9'd0, 64'd0, 4'd0}},
    // a single zero character, into the still empty slot 0
    '{'{64'h0000_0000_0000_0000, 4'd1}, 1'b1, '{1'b0, 1'b0, 4'd0, 9'd0, 64'd0, 4'd0}},
    // zero length key evicts the zero character into the second table
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0}, 1'b1, '{1'b0, 1'b1, 4'd0, 9'd1, 64'd0, 4'd0}},
    // all ones, full length, into the slot the zero length key left empty
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8}, 1'b1, '{1'b0, 1'b0, 4'd0, 9'd0, 64'd0, 4'd0}},
    // overlong length, cut to eight characters; loops until it is dropped
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15}, 1'b0, '0},
    // 'A' again: the stored 'A' moves to slot 5 of the second table
    '{'{64'h0000_0000_0000_0041, 4'd1}, 1'b1, '{1'b0, 1'b1, 4'd5, 9'd1, 64'd0, 4'd0}},
    // junk above the length must be ignored, so this is 'A' once more
    '{'{64'hDEAD_BEEF_CAFE_0041, 4'd1}, 1'b0, '0},
    '{'{64'h0000_0000_0000_0001, 4'd8}, 1'b0, '0},
    '{'{64'h8000_0000_0000_0000, 4'd8}, 1'b0, '0},
    '{'{64'h0102_0304_0506_0708, 4'd7}, 1'b0, '0},
    '{'{64'h6867_6665_6463_6261, 4'd8}, 1'b0, '0},
    '{'{64'h55AA_55AA_55AA_55AA, 4'd9}, 1'b0, '0},
    '{'{64'hAA55_AA55_AA55_AA55, 4'd4}, 1'b0, '0},
    '{'{64'h0000_0000_0000_7F7F, 4'd2}, 1'b0, '0},
    '{'{64'h0000_0000_0000_FF80, 4'd3}, 1'b0, '0}
  };

  // Random phases: eviction limit range and number of keys. The extremes of
  // the limit come early; the last phase runs with no stalls at all.
  localparam int unsigned PHASE_LO  [N_PHASES] = '{0, 255, 5, 1, 9, 30, 20};
  localparam int unsigned PHASE_HI  [N_PHASES] = '{0, 255, 5, 1, 9, 64, 20};
  localparam int unsigned PHASE_CNT [N_PHASES] = '{250, 20, 300, 150, 300, 150, 230};

  logic clk_i = 1'b0;
  logic rst_ni;

  chi_chan_if #(.payload_t(key_t))               key_if ();
  chi_chan_if #(.payload_t(res_t))               res_if ();
  chi_chan_if #(.payload_t(logic [MAXK_W-1:0]))  cfg_if ();

  cuckoo_hash_insert_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state: both tables, and the eviction limit as last written.
  logic [CHARS_W-1:0] slot_chars [2][TABLE_SLOTS_DEF] = '{default: '0};
  logic [LEN_W-1:0]   slot_len   [2][TABLE_SLOTS_DEF] = '{default: '0};
  logic [MAXK_W-1:0]  kick_limit = MAX_KICKS_RESET;

  res_t    expected_res [$];
  preset_t preset_q     [$];
  int unsigned mismatches = 0;
  int unsigned res_seen   = 0;
  int unsigned quiet_left = 0;
  bit          calm_run   = 1'b0;

  // Polynomial hash over the first n characters, reduced at every step.
  function automatic int unsigned hash_slot(logic [CHARS_W-1:0] chars, int unsigned n,
                                            int unsigned mul);
    int unsigned h;
    h = 0;
    for (int unsigned i = 0; i < n; i++) begin
      h = (h * mul + chars[8*i +: 8]) % TABLE_SLOTS_DEF;
    end
    return h;
  endfunction

  // Insert one key into the model tables and return the result it should
  // produce. Each pass writes the carried key and picks up the old occupant;
  // a pass that finds the depth beyond the limit drops the carried key.
  function automatic res_t insert_key(key_t k);
    logic [CHARS_W-1:0] chars;
    logic [CHARS_W-1:0] old_chars;
    logic [LEN_W-1:0]   old_len;
    int unsigned n;
    int unsigned side;
    int unsigned depth;
    int unsigned pos;
    res_t r;
    r = '0;
    n = k.key_len;
    if (n > KEY_CHARS_DEF) n = KEY_CHARS_DEF;
    chars = (n >= 8) ? k.key_chars : (k.key_chars & ((64'd1 << (8 * n)) - 64'd1));
    side  = 0;
    depth = 0;
    forever begin
      if (depth > kick_limit) begin
        r.status        = 1'b1;
        r.dropped_chars = chars;
        r.dropped_len   = n[LEN_W-1:0];
        break;
      end
      pos = hash_slot(chars, n, (side != 0) ? MUL_SECOND : MUL_FIRST);
      old_chars = slot_chars[side][pos];
      old_len   = slot_len[side][pos];
      slot_chars[side][pos] = chars;
      slot_len[side][pos]   = n[LEN_W-1:0];
      r.final_table = side[0];
      r.final_slot  = pos[SLOT_W-1:0];
      if (old_len == '0) break;
      chars = old_chars;
      n     = old_len;
      side  = side ^ 1;
      depth++;
    end
    r.kick_count = depth[KICK_W-1:0];
    return r;
  endfunction

  // Random keys: mostly legal lengths, some of length zero and some overlong,
  // with characters drawn so that collisions and repeats are frequent.
  function automatic key_t random_key();
    key_t k;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)      k.key_len = 4'd0;
    else if (pick <= 2) k.key_len = 4'($urandom_range(9, 15));
    else                k.key_len = 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      k.key_chars = '0;
    end else if (pick == 1) begin
      k.key_chars = '1;
    end else if (pick <= 4) begin
      for (int i = 0; i < 8; i++) k.key_chars[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
    end else begin
      k.key_chars = {$urandom, $urandom};
    end
    return k;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h", res_seen, name, got,
                       want));
  endtask

  // Lower the key valid and hold off until every expected result is in.
  task automatic settle();
    key_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (expected_res.size() == 0);
    @(posedge clk_i);
  endtask

  // Offer one key and wait for it to be taken. Outside the calm stretches it
  // may first idle for a burst, or now and then wait for the core to drain.
  task automatic send_key(input key_t k, input logic fixed, input res_t r);
    int unsigned gap;
    bit quiet;
    gap   = 0;
    quiet = calm_run;
    if (!quiet) begin
      if (quiet_left > 0) begin
        quiet_left--;
        quiet = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        quiet_left = $urandom_range(10, 60);
      end
    end
    if (!quiet && $urandom_range(0, 99) == 0) begin
      settle();
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    preset_q.push_back('{fixed, r});
    key_if.valid <= 1'b1;
    key_if.data  <= k;
    do @(posedge clk_i); while (!key_if.ready);
  endtask

  task automatic write_limit(input logic [MAXK_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // One monitor for all three channels, so that the order in which the
  // handshakes of one edge are seen never depends on the scheduler.
  always @(posedge clk_i) begin
    preset_t p;
    res_t    got;
    res_t    want;
    res_t    model;
    if (cfg_if.valid && cfg_if.ready) kick_limit = cfg_if.data;
    if (key_if.valid && key_if.ready) begin
      p     = preset_q.pop_front();
      model = insert_key(key_if.data);
      expected_res.push_back(p.fixed ? p.r : model);
    end
    if (res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_res.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", res_seen));
      end else begin
        want = expected_res.pop_front();
        check_field("status",        got.status,        want.status);
        check_field("final_table",   got.final_table,   want.final_table);
        check_field("final_slot",    got.final_slot,    want.final_slot);
        check_field("kick_count",    got.kick_count,    want.kick_count);
        check_field("dropped_chars", got.dropped_chars, want.dropped_chars);
        check_field("dropped_len",   got.dropped_len,   want.dropped_len);
      end
      res_seen++;
    end
  end

  // Result side: ready drops in random bursts until the calm phase.
  initial begin
    res_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!calm_run && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // Stimulus. The core clears its tables after reset and holds keys off
  // meanwhile, which the handshake takes care of.
  initial begin
    rst_ni       = 1'b0;
    key_if.valid = 1'b0;
    key_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed rows run under the reset value of the limit.
    for (int unsigned i = 0; i < N_DIRECTED; i++) begin
      send_key(DIRECTED[i].k, DIRECTED[i].fixed, DIRECTED[i].r);
    end
    settle();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      write_limit(MAXK_W'($urandom_range(PHASE_LO[ph], PHASE_HI[ph])));
      if (ph == N_PHASES - 1) calm_run = 1'b1;
      for (int unsigned i = 0; i < PHASE_CNT[ph]; i++) begin
        send_key(random_key(), 1'b0, '0);
      end
      settle();
    end

    // Leave room for any result the core should not produce.
    repeat (300) @(posedge clk_i);
    if (mismatches == 0)
      $display("** cuckoo_hash_insert_core: PASSED **");
    else
      $display("** cuckoo_hash_insert_core: FAILED **");
    $finish;
  end

  // A correct run needs well under a fifth of this, even with every key
  // walking its longest eviction chain under the longest stalls.
  initial begin
    #60ms;
    $display("** cuckoo_hash_insert_core: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/chi_pkg.sv
rtl/chi_chan_if.sv
rtl/chi_hash.sv
rtl/chi_dp.sv
rtl/chi_ctrl.sv
rtl/cuckoo_hash_insert_core.sv
test/tb_cuckoo_hash_insert_core.sv
